// ----- hw/rtl/lcdns_pkg.sv -----
// Types, codes and the power-up init program of the character LCD nibble sequencer.
// Used by lcdns_ctrl, lcdns_datapath and char_lcd_nibble_sequencer; depends on nothing.
package lcdns_pkg;

  typedef enum logic [3:0] {
    CMD_INIT      = 4'd0,
    CMD_CLEAR     = 4'd1,
    CMD_HOME      = 4'd2,
    CMD_POSITION  = 4'd3,
    CMD_DISPLAY   = 4'd4,
    CMD_ENTRY     = 4'd5,
    CMD_DSHIFT    = 4'd6,
    CMD_CSTEP     = 4'd7,
    CMD_GLYPH     = 4'd8,
    CMD_CHAR      = 4'd9,
    CMD_BACKLIGHT = 4'd10
  } cmd_e;

  typedef enum logic [1:0] {
    OP_PAUSE,   // one entry, no write, wait only
    OP_SINGLE,  // one entry, written byte holds only backlight
    OP_NIBBLE,  // one nibble, three entries
    OP_BYTE     // two nibbles, six entries
  } op_kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic [3:0] command;
    logic [7:0] char_code;
    logic [5:0] column;
    logic [1:0] row;
    logic [2:0] glyph_slot;
    logic       display_on;
    logic       cursor_on;
    logic       blink_on;
    logic       move_left;
    logic       auto_shift;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  expander_byte;
    logic        write_valid;
    logic [15:0] wait_after_us;
    logic        last;
  } out_item_t;

  typedef struct packed {
    op_kind_e    kind;
    logic [7:0]  value;
    logic        rs;
    logic [15:0] extra;
  } op_t;

  typedef struct packed {
    logic       accept;
    logic       load;
    logic [3:0] op_idx;
    logic [2:0] sub_idx;
    logic       last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic     has_out;
    op_kind_e kind;
    logic     op_last;
    logic     out_busy;
  } dp_status_t;

  localparam logic [3:0]  InitLastOp  = 4'd10;
  localparam logic [15:0] WaitPulse   = 16'd1;
  localparam logic [15:0] WaitSettle  = 16'd50;
  localparam logic [15:0] WaitPowerUp = 16'd50000;
  localparam logic [15:0] WaitZero    = 16'd1000;
  localparam logic [15:0] WaitFirst   = 16'd4500;
  localparam logic [15:0] WaitThird   = 16'd120;
  localparam logic [15:0] WaitClear   = 16'd2000;

  // Power-up init program: pause, zero byte, 8-bit wakeup nibbles, the 4-bit switch nibble, then setup bytes.
  function automatic op_t init_op(input logic [3:0] idx, input logic [2:0] disp,
                                  input logic [1:0] ent);
    op_t op;
    op = '{kind: OP_BYTE, value: 8'h00, rs: 1'b0, extra: 16'd0};
    case (idx)
      4'd0: begin
        op.kind  = OP_PAUSE;
        op.extra = WaitPowerUp;
      end
      4'd1: begin
        op.kind  = OP_SINGLE;
        op.extra = WaitZero;
      end
      4'd2, 4'd3: begin
        op.kind  = OP_NIBBLE;
        op.value = 8'h30;
        op.extra = WaitFirst;
      end
      4'd4: begin
        op.kind  = OP_NIBBLE;
        op.value = 8'h30;
        op.extra = WaitThird;
      end
      4'd5: begin
        op.kind  = OP_NIBBLE;
        op.value = 8'h20;
      end
      4'd6: op.value = 8'h28;
      4'd7: op.value = {5'b00001, disp};
      4'd8: begin
        op.value = 8'h01;
        op.extra = WaitClear;
      end
      4'd9: op.value = {6'b000001, ent};
      default: begin
        op.value = 8'h02;
        op.extra = WaitClear;
      end
    endcase
    return op;
  endfunction

endpackage

// ----- hw/rtl/lcdns_ctrl.sv -----
// Controller of the LCD nibble sequencer: walks operations and their entries.
// Depends on lcdns_pkg; drives lcdns_datapath through ctrl_cmd_t.
module lcdns_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  lcdns_pkg::dp_status_t  status_i,
  output lcdns_pkg::ctrl_cmd_t   cmd_o
);

  lcdns_pkg::state_e state_q, state_d;
  logic [3:0] op_idx_q, op_idx_d;
  logic [2:0] sub_q, sub_d;
  logic [2:0] sub_last;
  logic       entry_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lcdns_pkg::ST_IDLE;
      op_idx_q <= 4'd0;
      sub_q    <= 3'd0;
    end else begin
      state_q  <= state_d;
      op_idx_q <= op_idx_d;
      sub_q    <= sub_d;
    end
  end

  always_comb begin
    case (status_i.kind)
      lcdns_pkg::OP_NIBBLE: sub_last = 3'd2;
      lcdns_pkg::OP_BYTE:   sub_last = 3'd5;
      default:              sub_last = 3'd0;
    endcase
  end

  assign entry_done = (sub_q == sub_last);

  always_comb begin
    state_d  = state_q;
    op_idx_d = op_idx_q;
    sub_d    = sub_q;
    cmd_o    = '0;
    cmd_o.op_idx  = op_idx_q;
    cmd_o.sub_idx = sub_q;
    cmd_o.last    = entry_done && status_i.op_last;
    in_stall_o    = 1'b1;
    case (state_q)
      lcdns_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.has_out) begin
          state_d  = lcdns_pkg::ST_RUN;
          op_idx_d = 4'd0;
          sub_d    = 3'd0;
        end
      end
      lcdns_pkg::ST_RUN: begin
        // advance one entry per transfer slot of the output register
        if (!status_i.out_busy) begin
          cmd_o.load = 1'b1;
          if (!entry_done) begin
            sub_d = sub_q + 3'd1;
          end else if (status_i.op_last) begin
            state_d = lcdns_pkg::ST_IDLE;
          end else begin
            op_idx_d = op_idx_q + 4'd1;
            sub_d    = 3'd0;
          end
        end
      end
      default: state_d = lcdns_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/lcdns_datapath.sv -----
// Datapath of the LCD nibble sequencer: operands, display state and output register.
// Depends on lcdns_pkg; steered by lcdns_ctrl.
module lcdns_datapath #(
  parameter int COLUMNS = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lcdns_pkg::in_item_t   in_item_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_data_i,
  input  lcdns_pkg::ctrl_cmd_t  cmd_i,
  output lcdns_pkg::dp_status_t status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lcdns_pkg::out_item_t  out_item_o
);

  localparam logic [5:0] ColMax = 6'(COLUMNS);

  logic [3:0] cmd_q;
  logic [7:0] char_q;
  logic [7:0] pos_q;
  logic [2:0] slot_q;
  logic       left_q;
  logic [2:0] disp_q, disp_d;
  logic [1:0] entry_q, entry_d;
  logic       backlight_q;
  logic       out_valid_q;
  lcdns_pkg::out_item_t out_q, entry_item;

  logic       pos_ok;
  logic [6:0] pos_addr;
  lcdns_pkg::op_t op;
  logic [3:0] nib;
  logic [1:0] phase;
  logic       final_entry;

  assign pos_ok = (in_item_i.column != 6'd0) && (in_item_i.column <= ColMax) &&
                  ((in_item_i.row == 2'd1) || (in_item_i.row == 2'd2));
  assign pos_addr = 7'(in_item_i.column) - 7'd1 +
                    ((in_item_i.row == 2'd1) ? 7'h00 : 7'h40);

  always_comb begin
    disp_d  = disp_q;
    entry_d = entry_q;
    if (cmd_i.accept && (in_item_i.command == lcdns_pkg::CMD_DISPLAY)) begin
      disp_d = {in_item_i.display_on, in_item_i.cursor_on, in_item_i.blink_on};
    end
    if (cmd_i.accept && (in_item_i.command == lcdns_pkg::CMD_ENTRY)) begin
      entry_d = {~in_item_i.move_left, in_item_i.auto_shift};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_q      <= 3'b100;
      entry_q     <= 2'b10;
      backlight_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      disp_q  <= disp_d;
      entry_q <= entry_d;
      if (cfg_valid_i) begin
        backlight_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q  <= in_item_i.command;
      char_q <= in_item_i.char_code;
      pos_q  <= {1'b1, pos_addr};
      slot_q <= in_item_i.glyph_slot;
      left_q <= in_item_i.move_left;
    end
    if (cmd_i.load) begin
      out_q <= entry_item;
    end
  end

  // Current operation
  always_comb begin
    op = '{kind: lcdns_pkg::OP_BYTE, value: 8'h00, rs: 1'b0, extra: 16'd0};
    case (cmd_q)
      lcdns_pkg::CMD_INIT:     op = lcdns_pkg::init_op(cmd_i.op_idx, disp_q, entry_q);
      lcdns_pkg::CMD_CLEAR: begin
        op.value = 8'h01;
        op.extra = lcdns_pkg::WaitClear;
      end
      lcdns_pkg::CMD_HOME: begin
        op.value = 8'h02;
        op.extra = lcdns_pkg::WaitClear;
      end
      lcdns_pkg::CMD_POSITION: op.value = pos_q;
      lcdns_pkg::CMD_DISPLAY:  op.value = {5'b00001, disp_q};
      lcdns_pkg::CMD_ENTRY:    op.value = {6'b000001, entry_q};
      lcdns_pkg::CMD_DSHIFT:   op.value = {5'b00011, ~left_q, 2'b00};
      lcdns_pkg::CMD_CSTEP:    op.value = {5'b00010, ~left_q, 2'b00};
      lcdns_pkg::CMD_GLYPH:    op.value = {2'b01, slot_q, 3'b000};
      lcdns_pkg::CMD_CHAR: begin
        op.value = char_q;
        op.rs    = 1'b1;
      end
      default:                 op.kind = lcdns_pkg::OP_SINGLE;
    endcase
  end

  // Entry within the operation: high nibble on entries 0..2, low nibble on 3..5
  always_comb begin
    case (cmd_i.sub_idx)
      3'd0:    phase = 2'd0;
      3'd1:    phase = 2'd1;
      3'd2:    phase = 2'd2;
      3'd3:    phase = 2'd0;
      3'd4:    phase = 2'd1;
      3'd5:    phase = 2'd2;
      default: phase = 2'd0;
    endcase
    nib = (cmd_i.sub_idx >= 3'd3) ? op.value[3:0] : op.value[7:4];
    final_entry = (phase == 2'd2) &&
                  ((op.kind == lcdns_pkg::OP_NIBBLE) || (cmd_i.sub_idx == 3'd5));

    entry_item.last = cmd_i.last;
    case (op.kind)
      lcdns_pkg::OP_PAUSE: begin
        entry_item.expander_byte = 8'h00;
        entry_item.write_valid   = 1'b0;
        entry_item.wait_after_us = op.extra;
      end
      lcdns_pkg::OP_SINGLE: begin
        entry_item.expander_byte = {4'h0, backlight_q, 3'b000};
        entry_item.write_valid   = 1'b1;
        entry_item.wait_after_us = op.extra;
      end
      default: begin
        entry_item.expander_byte = {nib, backlight_q, (phase == 2'd1), 1'b0, op.rs};
        entry_item.write_valid   = 1'b1;
        case (phase)
          2'd0:    entry_item.wait_after_us = 16'd0;
          2'd1:    entry_item.wait_after_us = lcdns_pkg::WaitPulse;
          default: entry_item.wait_after_us = lcdns_pkg::WaitSettle +
                                              (final_entry ? op.extra : 16'd0);
        endcase
      end
    endcase
  end

  always_comb begin
    status_o.has_out  = (in_item_i.command <= lcdns_pkg::CMD_BACKLIGHT) &&
                        ((in_item_i.command != lcdns_pkg::CMD_POSITION) || pos_ok);
    status_o.kind     = op.kind;
    status_o.op_last  = (cmd_q != lcdns_pkg::CMD_INIT) ||
                        (cmd_i.op_idx == lcdns_pkg::InitLastOp);
    status_o.out_busy = out_valid_q && out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- hw/rtl/char_lcd_nibble_sequencer.sv -----
// Top level of the character LCD nibble sequencer for a 4-bit LCD behind a port expander.
// Depends on lcdns_pkg, lcdns_ctrl and lcdns_datapath.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------
//   in      | input     | in_valid / stall   | lcdns_pkg::in_item_t
//   out     | output    | out_valid / stall  | lcdns_pkg::out_item_t
//   cfg     | input     | cfg_valid / ready  | backlight_on (1 bit)
//
// An operation is transferred in, then the controller emits its expander entries: six for
// a command or character byte, one for backlight refresh, 44 for init, one entry per cycle
// into the single output register while the output is not stalled.
// A rejected position or an unused code is taken in and emits no entry.
// Output stall holds the sequence; input stays stalled until the last entry is loaded.
// Reset restores display flags 0b100, entry flags 0b10 and backlight off.
module char_lcd_nibble_sequencer #(
  parameter int COLUMNS = 40
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lcdns_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lcdns_pkg::out_item_t out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i
);

  lcdns_pkg::ctrl_cmd_t  ctrl_cmd;
  lcdns_pkg::dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  lcdns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  lcdns_datapath #(
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (ctrl_cmd),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- tb/char_lcd_nibble_sequencer_checker.sv -----
// Scoreboard for the character LCD nibble sequencer: watches the item, result and
// register channels, predicts every expander entry and compares it with the block.
// Depends on lcdns_pkg for the item types, command codes and wait constants.
module char_lcd_nibble_sequencer_checker #(
  parameter int COLUMNS = 40
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  lcdns_pkg::in_item_t  in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  lcdns_pkg::out_item_t out_item_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic                 cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         MaxReports      = 10;
  localparam logic [7:0] BitBacklight    = 8'h08;
  localparam logic [7:0] BitEnable       = 8'h04;
  localparam logic       RsCmd           = 1'b0;
  localparam logic       RsData          = 1'b1;
  localparam logic [2:0] DisplayReset    = 3'b100;
  localparam logic [1:0] EntryReset      = 2'b10;
  // HD44780 instruction bytes
  localparam logic [7:0] LcdClear        = 8'h01;
  localparam logic [7:0] LcdHome         = 8'h02;
  localparam logic [7:0] LcdEntry        = 8'h04;
  localparam logic [7:0] LcdDisplay      = 8'h08;
  localparam logic [7:0] LcdCursorStep   = 8'h10;
  localparam logic [7:0] LcdDisplayShift = 8'h18;
  localparam logic [7:0] LcdShiftRight   = 8'h04;
  localparam logic [7:0] LcdFunctionSet  = 8'h28;
  localparam logic [7:0] LcdGlyphAddr    = 8'h40;
  localparam logic [7:0] LcdSetAddr      = 8'h80;
  localparam logic [7:0] WakeNibble      = 8'h30;
  localparam logic [7:0] FourBitNibble   = 8'h20;
  localparam logic [6:0] RowTwoBase      = 7'h40;

  logic                 backlight_q;
  logic [2:0]           display_flags_q;
  logic [1:0]           entry_flags_q;
  lcdns_pkg::out_item_t op_entries[$];
  lcdns_pkg::out_item_t lcd_writes_q[$];
  int                   error_count;

  function automatic void put_entry(input logic [7:0] lcd_byte, input logic wr,
                                    input logic [15:0] us);
    lcdns_pkg::out_item_t e;
    e.expander_byte = (wr && backlight_q) ? (lcd_byte | BitBacklight) : lcd_byte;
    e.write_valid   = wr;
    e.wait_after_us = us;
    e.last          = 1'b0;
    op_entries.push_back(e);
  endfunction

  // Fold a command's long wait into its final entry
  function automatic void stretch_wait(input logic [15:0] extra);
    lcdns_pkg::out_item_t e;
    e = op_entries.pop_back();
    e.wait_after_us = e.wait_after_us + extra;
    op_entries.push_back(e);
  endfunction

  function automatic void put_nibble(input logic [7:0] lcd_byte);
    logic [7:0] plain;
    plain = lcd_byte & ~BitEnable;
    put_entry(plain, 1'b1, '0);
    put_entry(plain | BitEnable, 1'b1, lcdns_pkg::WaitPulse);
    put_entry(plain, 1'b1, lcdns_pkg::WaitSettle);
  endfunction

  function automatic void put_byte(input logic [7:0] value, input logic rs);
    put_nibble({value[7:4], 3'b000, rs});
    put_nibble({value[3:0], 3'b000, rs});
  endfunction

  function automatic void predict_op(input lcdns_pkg::in_item_t op);
    logic [6:0]           addr;
    lcdns_pkg::out_item_t e;
    op_entries.delete();
    case (op.command)
      lcdns_pkg::CMD_INIT: begin
        put_entry(8'h00, 1'b0, lcdns_pkg::WaitPowerUp);
        put_entry(8'h00, 1'b1, lcdns_pkg::WaitZero);
        put_nibble(WakeNibble);
        stretch_wait(lcdns_pkg::WaitFirst);
        put_nibble(WakeNibble);
        stretch_wait(lcdns_pkg::WaitFirst);
        put_nibble(WakeNibble);
        stretch_wait(lcdns_pkg::WaitThird);
        put_nibble(FourBitNibble);
        put_byte(LcdFunctionSet, RsCmd);
        put_byte(LcdDisplay | {5'b0, display_flags_q}, RsCmd);
        put_byte(LcdClear, RsCmd);
        stretch_wait(lcdns_pkg::WaitClear);
        put_byte(LcdEntry | {6'b0, entry_flags_q}, RsCmd);
        put_byte(LcdHome, RsCmd);
        stretch_wait(lcdns_pkg::WaitClear);
      end
      lcdns_pkg::CMD_CLEAR: begin
        put_byte(LcdClear, RsCmd);
        stretch_wait(lcdns_pkg::WaitClear);
      end
      lcdns_pkg::CMD_HOME: begin
        put_byte(LcdHome, RsCmd);
        stretch_wait(lcdns_pkg::WaitClear);
      end
      lcdns_pkg::CMD_POSITION: begin
        // drop positions off the panel
        if (op.column >= 1 && op.column <= COLUMNS &&
            (op.row == 2'd1 || op.row == 2'd2)) begin
          addr = 7'(op.column - 1) + ((op.row == 2'd1) ? 7'h00 : RowTwoBase);
          put_byte(LcdSetAddr | {1'b0, addr}, RsCmd);
        end
      end
      lcdns_pkg::CMD_DISPLAY: begin
        display_flags_q = {op.display_on, op.cursor_on, op.blink_on};
        put_byte(LcdDisplay | {5'b0, display_flags_q}, RsCmd);
      end
      lcdns_pkg::CMD_ENTRY: begin
        entry_flags_q = {~op.move_left, op.auto_shift};
        put_byte(LcdEntry | {6'b0, entry_flags_q}, RsCmd);
      end
      lcdns_pkg::CMD_DSHIFT:
        put_byte(LcdDisplayShift | (op.move_left ? 8'h00 : LcdShiftRight), RsCmd);
      lcdns_pkg::CMD_CSTEP:
        put_byte(LcdCursorStep | (op.move_left ? 8'h00 : LcdShiftRight), RsCmd);
      lcdns_pkg::CMD_GLYPH:
        put_byte(LcdGlyphAddr | {2'b0, op.glyph_slot, 3'b000}, RsCmd);
      lcdns_pkg::CMD_CHAR:      put_byte(op.char_code, RsData);
      lcdns_pkg::CMD_BACKLIGHT: put_entry(8'h00, 1'b1, '0);
      default: ;
    endcase
    if (op_entries.size() > 0) begin
      e = op_entries.pop_back();
      e.last = 1'b1;
      op_entries.push_back(e);
    end
    foreach (op_entries[i]) lcd_writes_q.push_back(op_entries[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lcdns_pkg::out_item_t want;
    if (!rst_ni) begin
      backlight_q     = 1'b0;
      display_flags_q = DisplayReset;
      entry_flags_q   = EntryReset;
      lcd_writes_q.delete();
      error_count     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) backlight_q = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (lcd_writes_q.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("%0t: unexpected expander entry byte=%02h wr=%0b wait=%0d last=%0b",
                     $realtime, out_item_i.expander_byte, out_item_i.write_valid,
                     out_item_i.wait_after_us, out_item_i.last);
        end else begin
          want = lcd_writes_q.pop_front();
          if (out_item_i.expander_byte !== want.expander_byte ||
              out_item_i.write_valid !== want.write_valid ||
              out_item_i.wait_after_us !== want.wait_after_us ||
              out_item_i.last !== want.last) begin
            error_count++;
            if (error_count <= MaxReports) begin
              $display("%0t: expander entry mismatch: expected byte=%02h wr=%0b wait=%0d last=%0b",
                       $realtime, want.expander_byte, want.write_valid,
                       want.wait_after_us, want.last);
              $display("%0t:   got byte=%02h wr=%0b wait=%0d last=%0b",
                       $realtime, out_item_i.expander_byte, out_item_i.write_valid,
                       out_item_i.wait_after_us, out_item_i.last);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_op(in_item_i);
    end
    fail_count_o = error_count;
    pending_o    = lcd_writes_q.size();
  end

endmodule

// ----- tb/tb_char_lcd_nibble_sequencer.sv -----
// Top of the nibble sequencer testbench: clock, reset, operation and backlight stimulus,
// random idling on both channels and the verdict. Depends on lcdns_pkg, the block
// and char_lcd_nibble_sequencer_checker.
module tb_char_lcd_nibble_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Columns      = 40;
  localparam int IdlePercent  = 29;
  localparam int SettleCycles = 50;
  localparam int IdleLimit    = 1000;
  localparam int LastCode     = 15;  // unused codes run to the top of the field

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  lcdns_pkg::in_item_t  in_item_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  lcdns_pkg::out_item_t out_item_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic                 cfg_data_i;
  logic                 calm = 1'b0;
  int                   fail_count;
  int                   pending;
  int                   idle_cycles = 0;

  char_lcd_nibble_sequencer #(
    .COLUMNS(Columns)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  char_lcd_nibble_sequencer_checker #(
    .COLUMNS(Columns)
  ) entry_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < IdlePercent);
  end

  // Count cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic lcdns_pkg::in_item_t with_cmd(input logic [3:0] cmd);
    logic [31:0]         r;
    lcdns_pkg::in_item_t op;
    r = $urandom;
    op = r[$bits(lcdns_pkg::in_item_t)-1:0];
    op.command = cmd;
    return op;
  endfunction

  function automatic lcdns_pkg::in_item_t random_op();
    int                  pick;
    lcdns_pkg::in_item_t op;
    pick = $urandom_range(99);
    if (pick < 5) begin
      op = with_cmd(lcdns_pkg::CMD_INIT);
    end else if (pick < 10) begin
      op = with_cmd(4'($urandom_range(int'(lcdns_pkg::CMD_BACKLIGHT) + 1, LastCode)));
    end else begin
      op = with_cmd(4'($urandom_range(int'(lcdns_pkg::CMD_CLEAR),
                                      int'(lcdns_pkg::CMD_BACKLIGHT))));
    end
    // keep most positions on the panel
    if (op.command == lcdns_pkg::CMD_POSITION && $urandom_range(3) != 0) begin
      op.column = 6'($urandom_range(1, Columns));
      op.row    = 2'($urandom_range(1, 2));
    end
    return op;
  endfunction

  // Enter at a rising edge; return at the edge of the transfer
  task automatic send_op(input lcdns_pkg::in_item_t op, input logic quiet);
    calm <= quiet;
    while (!quiet && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= op;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_position(input logic [5:0] col, input logic [1:0] row);
    lcdns_pkg::in_item_t op;
    op = with_cmd(lcdns_pkg::CMD_POSITION);
    op.column = col;
    op.row    = row;
    send_op(op, 1'b0);
  endtask

  task automatic send_flags(input logic [3:0] cmd, input logic [2:0] disp,
                            input logic left, input logic shift);
    lcdns_pkg::in_item_t op;
    op = with_cmd(cmd);
    {op.display_on, op.cursor_on, op.blink_on} = disp;
    op.move_left  = left;
    op.auto_shift = shift;
    send_op(op, 1'b0);
  endtask

  task automatic send_field(input logic [3:0] cmd, input logic [7:0] chr,
                            input logic [2:0] slot);
    lcdns_pkg::in_item_t op;
    op = with_cmd(cmd);
    op.char_code  = chr;
    op.glyph_slot = slot;
    send_op(op, 1'b0);
  endtask

  // Wait for the last result, then let any silent operation finish
  task automatic drain();
    in_valid_i <= 1'b0;
    calm       <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_backlight(input logic on);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= on;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int count, input int calm_from, input int calm_to);
    for (int i = 0; i < count; i++) begin
      send_op(random_op(), i >= calm_from && i < calm_to);
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: init with reset flags, every operation, position edges, unused codes
    send_op(with_cmd(lcdns_pkg::CMD_INIT), 1'b0);
    send_op(with_cmd(lcdns_pkg::CMD_CLEAR), 1'b0);
    send_op(with_cmd(lcdns_pkg::CMD_HOME), 1'b0);
    send_position(6'd1, 2'd1);
    send_position(6'(Columns), 2'd2);
    send_position(6'd0, 2'd1);
    send_position(6'(Columns + 1), 2'd1);
    send_position(6'h3F, 2'd2);
    send_position(6'd1, 2'd0);
    send_position(6'd1, 2'd3);
    send_flags(lcdns_pkg::CMD_DISPLAY, 3'b111, 1'b0, 1'b0);
    send_flags(lcdns_pkg::CMD_DISPLAY, 3'b010, 1'b1, 1'b1);
    send_flags(lcdns_pkg::CMD_ENTRY, 3'b000, 1'b0, 1'b1);
    send_flags(lcdns_pkg::CMD_ENTRY, 3'b101, 1'b1, 1'b0);
    send_flags(lcdns_pkg::CMD_DSHIFT, 3'b000, 1'b1, 1'b0);
    send_flags(lcdns_pkg::CMD_DSHIFT, 3'b111, 1'b0, 1'b1);
    send_flags(lcdns_pkg::CMD_CSTEP, 3'b000, 1'b1, 1'b1);
    send_flags(lcdns_pkg::CMD_CSTEP, 3'b111, 1'b0, 1'b0);
    send_field(lcdns_pkg::CMD_GLYPH, 8'h00, 3'd0);
    send_field(lcdns_pkg::CMD_GLYPH, 8'hFF, 3'd7);
    send_field(lcdns_pkg::CMD_CHAR, 8'h00, 3'd7);
    send_field(lcdns_pkg::CMD_CHAR, 8'hFF, 3'd0);
    send_op(with_cmd(lcdns_pkg::CMD_BACKLIGHT), 1'b0);
    send_op(with_cmd(4'(int'(lcdns_pkg::CMD_BACKLIGHT) + 1)), 1'b0);
    send_op(with_cmd(4'(LastCode)), 1'b0);
    send_op(with_cmd(lcdns_pkg::CMD_INIT), 1'b0);
    drain();

    write_backlight(1'b1);
    run_random(55, 10, 40);
    drain();
    write_backlight(1'b0);
    run_random(25, 0, 0);
    drain();
    write_backlight(1'b1);
    run_random(24, 0, 0);
    drain();

    @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- char_lcd_nibble_sequencer.f -----
hw/rtl/lcdns_pkg.sv
hw/rtl/lcdns_ctrl.sv
hw/rtl/lcdns_datapath.sv
hw/rtl/char_lcd_nibble_sequencer.sv
tb/char_lcd_nibble_sequencer_checker.sv
tb/tb_char_lcd_nibble_sequencer.sv
